>>> rtl/core/wdsa_pkg.sv
// shared types, constants and codes of the weighted descendant score accumulator
`default_nettype none

package wdsa_pkg;

   // default sizes
   localparam int NODES_DEF      = 4096;
   localparam int CANDIDATES_DEF = 256;
   localparam int MAX_DEGREE_DEF = 8;

   // field widths
   localparam int KIND_W  = 3;
   localparam int NODE_W  = 12;
   localparam int WGT_W   = 24;
   localparam int SLOT_W  = 8;
   localparam int PROB_W  = 17;
   localparam int DEG_W   = 4;
   localparam int CNT_W   = 13;
   localparam int SUM_W   = 36;
   localparam int CSC_W   = 48;
   localparam int WSC_W   = 64;
   localparam int HALF_W  = SUM_W / 2;

   localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(65536);

   // request kinds
   localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_NODE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CLOSE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_READ  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

   // csr port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_PROB  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMES_DEG = 1'd1;

   // shared multiplier operand select
   localparam logic [1:0] MUL_NONE = 2'd0;
   localparam logic [1:0] MUL_CNT  = 2'd1;
   localparam logic [1:0] MUL_LO   = 2'd2;
   localparam logic [1:0] MUL_HI   = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [NODE_W-1:0] node_id;
      logic [WGT_W-1:0]  weight_value;
      logic [SLOT_W-1:0] candidate_slot;
      logic [PROB_W-1:0] probability;
      logic [DEG_W-1:0]  out_degree;
   } req_payload_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_read;
      logic [CSC_W-1:0]  count_total;
      logic [WSC_W-1:0]  weight_total;
      logic              bad_weight_seen;
   } rsp_payload_type;

   typedef struct packed {
      logic       capture;
      logic       wt_load;
      logic       wt_read;
      logic       run_add;
      logic       run_clr;
      logic       err_clr;
      logic       score_rd;
      logic       score_wr;
      logic       sweep_wr;
      logic       mul_pm;
      logic [1:0] mul_sel;
      logic       cnt_take;
      logic       lo_take;
      logic       w_comb;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic rsp_free;
   } sts_type;

endpackage

`default_nettype wire

>>> rtl/core/wdsa_if.sv
// request and response channel interfaces
`default_nettype none

interface wdsa_req_if;
   logic                                valid;
   logic                                ready;
   logic [wdsa_pkg::KIND_W-1:0]         kind;
   logic [wdsa_pkg::NODE_W-1:0]         node_id;
   logic [wdsa_pkg::WGT_W-1:0]          weight_value;
   logic [wdsa_pkg::SLOT_W-1:0]         candidate_slot;
   logic [wdsa_pkg::PROB_W-1:0]         probability;
   logic [wdsa_pkg::DEG_W-1:0]          out_degree;

   modport source (
      output valid, kind, node_id, weight_value, candidate_slot, probability,
             out_degree,
      input  ready
   );
   modport sink (
      input  valid, kind, node_id, weight_value, candidate_slot, probability,
             out_degree,
      output ready
   );
endinterface

interface wdsa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [wdsa_pkg::SLOT_W-1:0] slot_read;
   logic [wdsa_pkg::CSC_W-1:0]  count_total;
   logic [wdsa_pkg::WSC_W-1:0]  weight_total;
   logic                        bad_weight_seen;

   modport source (
      output valid, slot_read, count_total, weight_total, bad_weight_seen,
      input  ready
   );
   modport sink (
      input  valid, slot_read, count_total, weight_total, bad_weight_seen,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/core/wdsa_ctrl.sv
// controller state machine sequencing each request through the datapath
`default_nettype none

module wdsa_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [wdsa_pkg::KIND_W-1:0] req_kind,
   output logic                             req_ready,
   input  wire wdsa_pkg::sts_type           sts,
   output wdsa_pkg::cmd_type                cmd
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_ADD      = 4'd1;
   localparam logic [3:0] ST_RD_ISSUE = 4'd2;
   localparam logic [3:0] ST_RD_OUT   = 4'd3;
   localparam logic [3:0] ST_C_PM     = 4'd4;
   localparam logic [3:0] ST_C_CNT    = 4'd5;
   localparam logic [3:0] ST_C_LO     = 4'd6;
   localparam logic [3:0] ST_C_HI     = 4'd7;
   localparam logic [3:0] ST_C_COMB   = 4'd8;
   localparam logic [3:0] ST_C_WR     = 4'd9;
   localparam logic [3:0] ST_SWEEP    = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               case (req_kind)
                  wdsa_pkg::KIND_LOAD: begin
                     cmd.wt_load = 1'b1;
                  end
                  wdsa_pkg::KIND_NODE: begin
                     cmd.wt_read = 1'b1;
                     state_in    = ST_ADD;
                  end
                  wdsa_pkg::KIND_CLOSE: begin
                     state_in = ST_C_PM;
                  end
                  wdsa_pkg::KIND_READ: begin
                     state_in = ST_RD_ISSUE;
                  end
                  wdsa_pkg::KIND_CLEAR: begin
                     cmd.run_clr = 1'b1;
                     cmd.err_clr = 1'b1;
                     state_in    = ST_SWEEP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD: begin
            cmd.run_add = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_RD_ISSUE: begin
            cmd.score_rd = 1'b1;
            state_in     = ST_RD_OUT;
         end
         ST_RD_OUT: begin
            // hold until the response register is free
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_C_PM: begin
            cmd.mul_pm   = 1'b1;
            cmd.score_rd = 1'b1;
            state_in     = ST_C_CNT;
         end
         ST_C_CNT: begin
            cmd.mul_sel = wdsa_pkg::MUL_CNT;
            state_in    = ST_C_LO;
         end
         ST_C_LO: begin
            cmd.mul_sel  = wdsa_pkg::MUL_LO;
            cmd.cnt_take = 1'b1;
            state_in     = ST_C_HI;
         end
         ST_C_HI: begin
            cmd.mul_sel = wdsa_pkg::MUL_HI;
            cmd.lo_take = 1'b1;
            state_in    = ST_C_COMB;
         end
         ST_C_COMB: begin
            cmd.w_comb = 1'b1;
            state_in   = ST_C_WR;
         end
         ST_C_WR: begin
            cmd.score_wr = 1'b1;
            cmd.run_clr  = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SWEEP: begin
            cmd.sweep_wr = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // reset starts with a zeroing pass over the score stores
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/wdsa_dp.sv
// datapath: weight store, running sum, shared multiplier, score stores, response register
`default_nettype none

module wdsa_dp #(
   parameter int NODES      = wdsa_pkg::NODES_DEF,
   parameter int CANDIDATES = wdsa_pkg::CANDIDATES_DEF,
   parameter int MAX_DEGREE = wdsa_pkg::MAX_DEGREE_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire wdsa_pkg::req_payload_type       req,
   input  wire wdsa_pkg::cmd_type               cmd,
   output wdsa_pkg::sts_type                    sts,
   input  wire logic                            csr_we,
   input  wire logic [wdsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [wdsa_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output wdsa_pkg::rsp_payload_type            rsp
);

   localparam int NAW = $clog2(NODES);
   localparam int CAW = (CANDIDATES > 1) ? $clog2(CANDIDATES) : 1;
   localparam int MW  = $clog2(MAX_DEGREE + 1);
   localparam int PMW = wdsa_pkg::PROB_W + MW;
   localparam int PRW = PMW + wdsa_pkg::HALF_W;
   localparam int HW  = wdsa_pkg::HALF_W;

   // csr
   logic use_prob_ff;
   logic times_deg_ff;

   // captured request
   logic                          node_ok_ff;
   logic                          slot_ok_ff;
   logic [wdsa_pkg::SLOT_W-1:0]   slot_ff;
   logic [wdsa_pkg::PROB_W-1:0]   p_ff;
   logic [MW-1:0]                 m_ff;
   logic                          node_ok_in;
   logic                          slot_ok_in;
   logic [wdsa_pkg::PROB_W-1:0]   p_in;
   logic [MW-1:0]                 m_in;

   // weight store
   logic [wdsa_pkg::WGT_W-1:0]    wmem [NODES];
   logic [wdsa_pkg::WGT_W-1:0]    wrd_ff;

   // running accumulation
   logic [wdsa_pkg::CNT_W-1:0]    run_cnt_ff;
   logic [wdsa_pkg::SUM_W-1:0]    run_sum_ff;
   logic [wdsa_pkg::SUM_W:0]      sum_ext;
   logic                          err_ff;

   // shared multiplier
   logic [PMW-1:0]                pm_ff;
   logic [HW-1:0]                 mul_b;
   logic [PRW-1:0]                prod;
   logic [PRW-1:0]                mul_ff;
   logic [PRW-1:0]                lo_ff;
   logic [wdsa_pkg::CSC_W-1:0]    incc_ff;
   logic [wdsa_pkg::WSC_W-1:0]    incw_ff;

   // score stores
   logic [wdsa_pkg::CSC_W-1:0]    cmem [CANDIDATES];
   logic [wdsa_pkg::WSC_W-1:0]    wsmem [CANDIDATES];
   logic [wdsa_pkg::CSC_W-1:0]    crd_ff;
   logic [wdsa_pkg::WSC_W-1:0]    wsrd_ff;
   logic [wdsa_pkg::CSC_W:0]      c_sum;
   logic [wdsa_pkg::WSC_W:0]      w_sum;
   logic [wdsa_pkg::CSC_W-1:0]    c_new;
   logic [wdsa_pkg::WSC_W-1:0]    w_new;
   logic                          s_we;
   logic [CAW-1:0]                s_addr;
   logic [CAW-1:0]                sweep_ff;
   logic                          sweep_last;

   // response register
   logic                          rsp_valid_ff;
   wdsa_pkg::rsp_payload_type     rsp_ff;

   assign node_ok_in = (32'(req.node_id) < NODES);
   assign slot_ok_in = (32'(req.candidate_slot) < CANDIDATES);

   always_comb begin
      if (!use_prob_ff || (req.probability > wdsa_pkg::ONE_Q16)) begin
         p_in = wdsa_pkg::ONE_Q16;
      end else begin
         p_in = req.probability;
      end
      if (!times_deg_ff) begin
         m_in = MW'(1);
      end else if (32'(req.out_degree) > MAX_DEGREE) begin
         m_in = MW'(MAX_DEGREE);
      end else begin
         m_in = MW'(req.out_degree);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         node_ok_ff <= node_ok_in;
         slot_ok_ff <= slot_ok_in;
         slot_ff    <= req.candidate_slot;
         p_ff       <= p_in;
         m_ff       <= m_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_prob_ff  <= 1'b1;
         times_deg_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            wdsa_pkg::CSR_USE_PROB:  use_prob_ff  <= csr_wdata[0];
            wdsa_pkg::CSR_TIMES_DEG: times_deg_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // weight store, a zero weight is rejected and flagged
   always_ff @(posedge clock) begin
      if (cmd.wt_load && node_ok_in && (req.weight_value != '0)) begin
         wmem[NAW'(req.node_id)] <= req.weight_value;
      end
      if (cmd.wt_read) begin
         wrd_ff <= wmem[NAW'(req.node_id)];
      end
   end

   assign sum_ext = {1'b0, run_sum_ff} + (wdsa_pkg::SUM_W + 1)'(wrd_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_cnt_ff <= '0;
         run_sum_ff <= '0;
         err_ff     <= 1'b0;
      end else begin
         if (cmd.run_clr) begin
            run_cnt_ff <= '0;
            run_sum_ff <= '0;
         end else if (cmd.run_add && node_ok_ff) begin
            if (run_cnt_ff != '1) begin
               run_cnt_ff <= run_cnt_ff + 1'b1;
            end
            run_sum_ff <= sum_ext[wdsa_pkg::SUM_W] ? '1 : sum_ext[wdsa_pkg::SUM_W-1:0];
         end
         if (cmd.err_clr) begin
            err_ff <= 1'b0;
         end else if (cmd.wt_load && (req.weight_value == '0)) begin
            err_ff <= 1'b1;
         end
      end
   end

   // one multiplier, three passes: count, low and high half of the sum
   always_comb begin
      case (cmd.mul_sel)
         wdsa_pkg::MUL_CNT: mul_b = HW'(run_cnt_ff);
         wdsa_pkg::MUL_LO:  mul_b = run_sum_ff[HW-1:0];
         wdsa_pkg::MUL_HI:  mul_b = run_sum_ff[wdsa_pkg::SUM_W-1:HW];
         default:           mul_b = '0;
      endcase
   end

   assign prod = PRW'(pm_ff) * PRW'(mul_b);

   always_ff @(posedge clock) begin
      if (cmd.mul_pm) begin
         pm_ff <= PMW'(p_ff) * PMW'(m_ff);
      end
      if (cmd.mul_sel != wdsa_pkg::MUL_NONE) begin
         mul_ff <= prod;
      end
      if (cmd.cnt_take) begin
         incc_ff <= wdsa_pkg::CSC_W'(mul_ff);
      end
      if (cmd.lo_take) begin
         lo_ff <= mul_ff;
      end
      if (cmd.w_comb) begin
         incw_ff <= (wdsa_pkg::WSC_W'(mul_ff) << HW) + wdsa_pkg::WSC_W'(lo_ff);
      end
   end

   // saturating accumulate
   assign c_sum = {1'b0, crd_ff} + (wdsa_pkg::CSC_W + 1)'(incc_ff);
   assign w_sum = {1'b0, wsrd_ff} + (wdsa_pkg::WSC_W + 1)'(incw_ff);
   assign c_new = c_sum[wdsa_pkg::CSC_W] ? '1 : c_sum[wdsa_pkg::CSC_W-1:0];
   assign w_new = w_sum[wdsa_pkg::WSC_W] ? '1 : w_sum[wdsa_pkg::WSC_W-1:0];

   assign sweep_last = (sweep_ff == CAW'(CANDIDATES - 1));
   assign s_we       = cmd.sweep_wr || (cmd.score_wr && slot_ok_ff);
   assign s_addr     = cmd.sweep_wr ? sweep_ff : CAW'(slot_ff);

   always_ff @(posedge clock) begin
      if (s_we) begin
         cmem[s_addr]  <= cmd.sweep_wr ? '0 : c_new;
         wsmem[s_addr] <= cmd.sweep_wr ? '0 : w_new;
      end
      if (cmd.score_rd) begin
         crd_ff  <= cmem[CAW'(slot_ff)];
         wsrd_ff <= wsmem[CAW'(slot_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.sweep_wr) begin
         sweep_ff <= sweep_last ? '0 : sweep_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.slot_read       <= slot_ff;
         rsp_ff.count_total     <= slot_ok_ff ? crd_ff : '0;
         rsp_ff.weight_total    <= slot_ok_ff ? wsrd_ff : '0;
         rsp_ff.bad_weight_seen <= err_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp            = rsp_ff;
   assign sts.sweep_last = sweep_last;
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

>>> rtl/core/weighted_descendant_score_accumulator_top.sv
// top level of the weighted descendant score accumulator
`default_nettype none

// Requests are taken one at a time. A weight load is written as it is
// accepted, a valued node is a registered weight-store read, then the
// saturating add, a read is a score-store read plus any wait for the
// response register to drain, and a close uses one shared multiplier in
// three passes (count, low and high half of the 36-bit running sum) before
// the read-modify-write of the score stores. For a clear, the running sum,
// count and error flag are zeroed, then the score stores are swept one slot
// per cycle. After reset the same sweep runs while req_ch.ready is low; csr
// writes are taken at any time. A finished read waits in an output
// register, so the next request is accepted while it is pending.
module weighted_descendant_score_accumulator_top #(
   parameter int NODES      = wdsa_pkg::NODES_DEF,
   parameter int CANDIDATES = wdsa_pkg::CANDIDATES_DEF,
   parameter int MAX_DEGREE = wdsa_pkg::MAX_DEGREE_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   wdsa_req_if.sink                             req_ch,
   wdsa_rsp_if.source                           rsp_ch,
   input  wire logic                            csr_we,
   input  wire logic [wdsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [wdsa_pkg::CSR_DATA_W-1:0] csr_wdata
);

   wdsa_pkg::req_payload_type req_pl;
   wdsa_pkg::rsp_payload_type rsp_pl;
   wdsa_pkg::cmd_type         cmd;
   wdsa_pkg::sts_type         sts;
   logic                      req_ready;
   logic                      rsp_valid;

   assign req_pl.kind           = req_ch.kind;
   assign req_pl.node_id        = req_ch.node_id;
   assign req_pl.weight_value   = req_ch.weight_value;
   assign req_pl.candidate_slot = req_ch.candidate_slot;
   assign req_pl.probability    = req_ch.probability;
   assign req_pl.out_degree     = req_ch.out_degree;

   wdsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.kind),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   wdsa_dp #(
      .NODES      (NODES),
      .CANDIDATES (CANDIDATES),
      .MAX_DEGREE (MAX_DEGREE)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_pl),
      .cmd       (cmd),
      .sts       (sts),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .rsp       (rsp_pl)
   );

   assign req_ch.ready           = req_ready;
   assign rsp_ch.valid           = rsp_valid;
   assign rsp_ch.slot_read       = rsp_pl.slot_read;
   assign rsp_ch.count_total     = rsp_pl.count_total;
   assign rsp_ch.weight_total    = rsp_pl.weight_total;
   assign rsp_ch.bad_weight_seen = rsp_pl.bad_weight_seen;

   // reset always starts the zeroing sweep
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> !req_ch.ready)
      else $error("ready high right after reset");

   // a clear blocks requests while the score stores are swept
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && (req_ch.kind == wdsa_pkg::KIND_CLEAR))
      |=> !req_ch.ready)
      else $error("request taken during clear sweep");

   // only a read request produces a response
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && (req_ch.kind != wdsa_pkg::KIND_READ)
       && !rsp_ch.valid) |=> !rsp_ch.valid)
      else $error("response without a read request");

   // a read result cannot appear in the cycle after its request
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && !rsp_ch.valid) |=> !rsp_ch.valid)
      else $error("response earlier than the score store read");

endmodule

`default_nettype wire

>>> tb/weighted_descendant_score_accumulator_top_tb.sv
// self-checking testbench of the weighted descendant score accumulator top level
`timescale 1ns / 1ps

module weighted_descendant_score_accumulator_top_tb;

   localparam logic [wdsa_pkg::KIND_W-1:0] KIND_TOP  = '1;
   localparam logic [63:0]                 CSC_CEIL  = 64'({wdsa_pkg::CSC_W{1'b1}});
   localparam logic [63:0]                 WSC_CEIL  = '1;
   localparam int                          BURST_LEN = 64;

   // predicted slot scores, running sums and the expected read responses
   class slot_score_tracker;
      logic [wdsa_pkg::WGT_W-1:0] node_weight [wdsa_pkg::NODES_DEF];
      logic [wdsa_pkg::CSC_W-1:0] count_score [wdsa_pkg::CANDIDATES_DEF];
      logic [wdsa_pkg::WSC_W-1:0] weighted_sum [wdsa_pkg::CANDIDATES_DEF];
      logic [wdsa_pkg::CNT_W-1:0] run_count;
      logic [wdsa_pkg::SUM_W-1:0] run_sum;
      logic                       error_seen;
      logic                       use_prob;
      logic                       times_deg;
      wdsa_pkg::rsp_payload_type  pending_reads [$];
      int unsigned                failures;
      int unsigned                reads_checked;

      function new();
         foreach (node_weight[i]) node_weight[i] = '0;
         clear_scores();
         use_prob      = 1'b1;
         times_deg     = 1'b0;
         failures      = 0;
         reads_checked = 0;
      endfunction

      function void clear_scores();
         foreach (count_score[i]) begin
            count_score[i]  = '0;
            weighted_sum[i] = '0;
         end
         run_count  = '0;
         run_sum    = '0;
         error_seen = 1'b0;
      endfunction

      function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b, logic [63:0] ceil);
         logic [64:0] t;
         t = {1'b0, a} + {1'b0, b};
         return (t > {1'b0, ceil}) ? ceil : t[63:0];
      endfunction

      function void note_request(wdsa_pkg::req_payload_type r);
         logic [wdsa_pkg::PROB_W-1:0] p;
         logic [wdsa_pkg::DEG_W-1:0]  m;
         logic [63:0]                 pm;
         logic [wdsa_pkg::SUM_W:0]    s;
         wdsa_pkg::rsp_payload_type   want;
         case (r.kind)
            wdsa_pkg::KIND_LOAD: begin
               if (r.weight_value == '0) error_seen = 1'b1;
               else node_weight[r.node_id] = r.weight_value;
            end
            wdsa_pkg::KIND_NODE: begin
               if (run_count != '1) run_count++;
               s = {1'b0, run_sum} + (wdsa_pkg::SUM_W+1)'(node_weight[r.node_id]);
               run_sum = s[wdsa_pkg::SUM_W] ? '1 : s[wdsa_pkg::SUM_W-1:0];
            end
            wdsa_pkg::KIND_CLOSE: begin
               if (!use_prob) p = wdsa_pkg::ONE_Q16;
               else if (r.probability > wdsa_pkg::ONE_Q16) p = wdsa_pkg::ONE_Q16;
               else p = r.probability;
               if (!times_deg) m = wdsa_pkg::DEG_W'(1);
               else if (r.out_degree > wdsa_pkg::MAX_DEGREE_DEF)
                  m = wdsa_pkg::DEG_W'(wdsa_pkg::MAX_DEGREE_DEF);
               else m = r.out_degree;
               pm = 64'(p) * 64'(m);
               count_score[r.candidate_slot] = wdsa_pkg::CSC_W'(sat_sum(
                  64'(count_score[r.candidate_slot]), pm * 64'(run_count), CSC_CEIL));
               weighted_sum[r.candidate_slot] = sat_sum(
                  weighted_sum[r.candidate_slot], pm * 64'(run_sum), WSC_CEIL);
               run_count = '0;
               run_sum   = '0;
            end
            wdsa_pkg::KIND_READ: begin
               want.slot_read       = r.candidate_slot;
               want.count_total     = count_score[r.candidate_slot];
               want.weight_total    = weighted_sum[r.candidate_slot];
               want.bad_weight_seen = error_seen;
               pending_reads        = {pending_reads, want};
            end
            wdsa_pkg::KIND_CLEAR: clear_scores();
            default: ;
         endcase
      endfunction

      function void check_read(wdsa_pkg::rsp_payload_type got);
         wdsa_pkg::rsp_payload_type want;
         if (pending_reads.size() == 0) begin
            $error("response for slot %0d with no read pending", got.slot_read);
            failures++;
            return;
         end
         want = pending_reads.pop_front();
         reads_checked++;
         if (got.slot_read !== want.slot_read) begin
            $error("slot_read: expected %0d, got %0d", want.slot_read, got.slot_read);
            failures++;
         end
         if (got.count_total !== want.count_total) begin
            $error("count_total: expected %0h, got %0h",
                   want.count_total, got.count_total);
            failures++;
         end
         if (got.weight_total !== want.weight_total) begin
            $error("weight_total: expected %0h, got %0h",
                   want.weight_total, got.weight_total);
            failures++;
         end
         if (got.bad_weight_seen !== want.bad_weight_seen) begin
            $error("bad_weight_seen: expected %0b, got %0b",
                   want.bad_weight_seen, got.bad_weight_seen);
            failures++;
         end
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [wdsa_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [wdsa_pkg::CSR_DATA_W-1:0] csr_wdata;

   wdsa_req_if req_ch ();
   wdsa_rsp_if rsp_ch ();

   slot_score_tracker           scores = new();
   logic [wdsa_pkg::NODE_W-1:0] loaded_nodes [$];
   int unsigned                 send_calm;

   weighted_descendant_score_accumulator_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #4_000_000;
      $display("Mismatches found");
      $finish;
   end

   // mostly short stalls, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic int sender_gap();
      if (send_calm > 0) begin
         send_calm--;
         return 0;
      end
      if ($urandom_range(0, 99) < 5) begin
         send_calm = $urandom_range(10, 40);
         return 0;
      end
      if ($urandom_range(0, 99) < 55) return 0;
      return idle_len();
   endfunction

   function automatic wdsa_pkg::req_payload_type req_of(
      logic [wdsa_pkg::KIND_W-1:0] kind,
      logic [wdsa_pkg::NODE_W-1:0] node,
      logic [wdsa_pkg::WGT_W-1:0]  wval,
      logic [wdsa_pkg::SLOT_W-1:0] slot,
      logic [wdsa_pkg::PROB_W-1:0] prob,
      logic [wdsa_pkg::DEG_W-1:0]  deg);
      wdsa_pkg::req_payload_type r;
      r.kind           = kind;
      r.node_id        = node;
      r.weight_value   = wval;
      r.candidate_slot = slot;
      r.probability    = prob;
      r.out_degree     = deg;
      return r;
   endfunction

   function automatic logic [wdsa_pkg::PROB_W-1:0] draw_prob();
      case ($urandom_range(0, 5))
         0:       return wdsa_pkg::ONE_Q16;
         1:       return '0;
         2:       return wdsa_pkg::PROB_W'($urandom_range(0, {wdsa_pkg::PROB_W{1'b1}}));
         default: return wdsa_pkg::PROB_W'($urandom_range(0, wdsa_pkg::ONE_Q16));
      endcase
   endfunction

   function automatic logic [wdsa_pkg::SLOT_W-1:0] draw_slot();
      if ($urandom_range(0, 99) < 70) return wdsa_pkg::SLOT_W'($urandom_range(0, 15));
      return wdsa_pkg::SLOT_W'($urandom_range(0, wdsa_pkg::CANDIDATES_DEF - 1));
   endfunction

   // fields that the kind does not use carry random content
   function automatic wdsa_pkg::req_payload_type noisy_req(
      logic [wdsa_pkg::KIND_W-1:0] kind);
      return req_of(kind, wdsa_pkg::NODE_W'($urandom), wdsa_pkg::WGT_W'($urandom),
                    wdsa_pkg::SLOT_W'($urandom), wdsa_pkg::PROB_W'($urandom),
                    wdsa_pkg::DEG_W'($urandom));
   endfunction

   task automatic send_request(input wdsa_pkg::req_payload_type r, input int gap);
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid          <= 1'b1;
      req_ch.kind           <= r.kind;
      req_ch.node_id        <= r.node_id;
      req_ch.weight_value   <= r.weight_value;
      req_ch.candidate_slot <= r.candidate_slot;
      req_ch.probability    <= r.probability;
      req_ch.out_degree     <= r.out_degree;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      scores.note_request(r);
   endtask

   task automatic issue(input wdsa_pkg::req_payload_type r);
      if (r.kind == wdsa_pkg::KIND_LOAD && r.weight_value != '0)
         loaded_nodes = {loaded_nodes, r.node_id};
      send_request(r, sender_gap());
   endtask

   function automatic wdsa_pkg::req_payload_type node_req();
      wdsa_pkg::req_payload_type r;
      r = noisy_req(wdsa_pkg::KIND_NODE);
      r.node_id = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
      return r;
   endfunction

   // wait for all reads to come back, then for a clear sweep to finish
   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (scores.pending_reads.size() != 0) @(posedge clock);
      repeat (wdsa_pkg::CANDIDATES_DEF + 8) @(posedge clock);
   endtask

   task automatic configure(input logic use_p, input logic times_d);
      drain();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= wdsa_pkg::CSR_USE_PROB;
      csr_wdata <= use_p;
      @(negedge clock);
      csr_index <= wdsa_pkg::CSR_TIMES_DEG;
      csr_wdata <= times_d;
      @(negedge clock);
      csr_we <= 1'b0;
      scores.use_prob  = use_p;
      scores.times_deg = times_d;
   endtask

   task automatic run_random_phase(input int unsigned quota);
      int unsigned               sent;
      int                        pick;
      int                        n;
      wdsa_pkg::req_payload_type r;
      sent = 0;
      while (sent < quota) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            n = $urandom_range(0, 6);
            repeat (n) issue(node_req());
            r = noisy_req(wdsa_pkg::KIND_CLOSE);
            r.candidate_slot = draw_slot();
            r.probability    = draw_prob();
            issue(r);
            sent += n + 1;
         end else if (pick < 65) begin
            r = noisy_req(wdsa_pkg::KIND_READ);
            r.candidate_slot = draw_slot();
            issue(r);
            sent++;
         end else if (pick < 78) begin
            r = noisy_req(wdsa_pkg::KIND_LOAD);
            r.weight_value = wdsa_pkg::WGT_W'($urandom_range(1, {wdsa_pkg::WGT_W{1'b1}}));
            issue(r);
            sent++;
         end else if (pick < 81) begin
            r = noisy_req(wdsa_pkg::KIND_LOAD);
            r.weight_value = '0;
            issue(r);
            sent++;
         end else if (pick < 83) begin
            issue(noisy_req(wdsa_pkg::KIND_CLEAR));
            sent++;
         end else if (pick < 86) begin
            issue(noisy_req(wdsa_pkg::KIND_W'($urandom_range(
               int'(wdsa_pkg::KIND_CLEAR) + 1, int'(KIND_TOP)))));
         end else begin
            issue(node_req());
            sent++;
         end
      end
   endtask

   initial begin : rsp_monitor_init
      req_ch.valid          = 1'b0;
      req_ch.kind           = wdsa_pkg::KIND_LOAD;
      req_ch.node_id        = '0;
      req_ch.weight_value   = '0;
      req_ch.candidate_slot = '0;
      req_ch.probability    = '0;
      req_ch.out_degree     = '0;
      csr_we    = 1'b0;
      csr_index = wdsa_pkg::CSR_USE_PROB;
      csr_wdata = '0;
      send_calm = 0;
      reset     = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      configure(1'b1, 1'b1);
      issue(req_of(wdsa_pkg::KIND_LOAD, '0, '1, 8'd0, '0, '0));
      issue(req_of(wdsa_pkg::KIND_LOAD, '1, wdsa_pkg::WGT_W'(1), 8'd0, '0, '0));
      issue(req_of(wdsa_pkg::KIND_LOAD, 12'h555, 24'hAAAAAA, 8'd0, '0, '0));
      // zero weight is rejected and flags the error
      issue(req_of(wdsa_pkg::KIND_LOAD, 12'hAAA, '0, 8'd0, '0, '0));
      issue(req_of(wdsa_pkg::KIND_READ, '0, '0, 8'd0, '0, '0));
      issue(req_of(wdsa_pkg::KIND_CLEAR, '0, '0, 8'd0, '0, '0));
      issue(req_of(wdsa_pkg::KIND_NODE, '0, '0, 8'd0, '0, '0));
      issue(req_of(wdsa_pkg::KIND_NODE, '1, '0, 8'd0, '0, '0));
      issue(req_of(wdsa_pkg::KIND_NODE, 12'h555, '0, 8'd0, '0, '0));
      // probability above one and degree above the limit both clamp
      issue(req_of(wdsa_pkg::KIND_CLOSE, '0, '0, '1, '1, '1));
      issue(req_of(wdsa_pkg::KIND_READ, '0, '0, '1, '0, '0));
      issue(req_of(wdsa_pkg::KIND_CLOSE, '0, '0, 8'd0, '0, '0));
      issue(req_of(wdsa_pkg::KIND_NODE, '0, '0, 8'd0, '0, '0));
      issue(req_of(wdsa_pkg::KIND_CLOSE, '0, '0, 8'd0, wdsa_pkg::ONE_Q16,
                   wdsa_pkg::DEG_W'(wdsa_pkg::MAX_DEGREE_DEF)));
      issue(req_of(wdsa_pkg::KIND_READ, '0, '0, 8'd0, '0, '0));
      issue(req_of(wdsa_pkg::KIND_NODE, '1, '0, 8'd0, '0, '0));
      issue(req_of(wdsa_pkg::KIND_CLOSE, '0, '0, 8'd1, wdsa_pkg::PROB_W'(1),
                   wdsa_pkg::DEG_W'(1)));
      issue(req_of(wdsa_pkg::KIND_CLEAR + wdsa_pkg::KIND_W'(1), '1, '1, 8'd1, '1, '1));
      issue(req_of(KIND_TOP, '1, '1, 8'd1, '1, '1));
      issue(req_of(wdsa_pkg::KIND_READ, '0, '0, 8'd1, '0, '0));
      issue(req_of(wdsa_pkg::KIND_NODE, 12'h555, '0, 8'd0, '0, '0));
      issue(req_of(wdsa_pkg::KIND_CLOSE, '0, '0, 8'd128, wdsa_pkg::ONE_Q16, '0));
      issue(req_of(wdsa_pkg::KIND_READ, '0, '0, 8'd128, '0, '0));

      configure(1'b0, 1'b0);
      run_random_phase(300);

      configure(1'b1, 1'b1);
      // back-to-back run of valued nodes at the largest weight
      issue(req_of(wdsa_pkg::KIND_LOAD, '0, '1, 8'd0, '0, '0));
      for (int i = 0; i < BURST_LEN; i++)
         send_request(req_of(wdsa_pkg::KIND_NODE, '0, wdsa_pkg::WGT_W'($urandom),
                             8'd0, '0, '0), 0);
      issue(req_of(wdsa_pkg::KIND_CLOSE, '0, '0, 8'd200, wdsa_pkg::ONE_Q16,
                   wdsa_pkg::DEG_W'(wdsa_pkg::MAX_DEGREE_DEF)));
      issue(req_of(wdsa_pkg::KIND_READ, '0, '0, 8'd200, '0, '0));
      run_random_phase(300);

      configure(1'b0, 1'b1);
      run_random_phase(300);

      configure(1'b1, 1'b0);
      run_random_phase(300);

      drain();
      if (scores.failures == 0 && scores.pending_reads.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin : rsp_sink
      int unsigned hold_left;
      int unsigned calm_left;
      bit          pressed;
      hold_left = 0;
      calm_left = 0;
      pressed   = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         // one long hold-off so reads back up and the request side stalls
         if (!pressed && scores.reads_checked >= 30) begin
            pressed   = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(0, 99) < 8) calm_left = $urandom_range(20, 80);
            else if ($urandom_range(0, 99) < 30) hold_left = idle_len();
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      wdsa_pkg::rsp_payload_type got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.slot_read       = rsp_ch.slot_read;
         got.count_total     = rsp_ch.count_total;
         got.weight_total    = rsp_ch.weight_total;
         got.bad_weight_seen = rsp_ch.bad_weight_seen;
         scores.check_read(got);
      end
   end

endmodule
